// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the date difference RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define DDD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define DDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ddd_pkg.sv =====
// Shared widths, constants and the month table of the date difference block.
// No dependencies; imported by ddd_serial and date_day_difference.
package ddd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 22;
    localparam int SERIAL_W = 23;
    localparam int DBM_W    = 9;
    localparam int QUO_W    = 9;
    localparam int DIVIN_W  = 13;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    // floor(2^20 / 25); estimate is low by at most one, fixed by one compare
    localparam logic [15:0] RECIP25 = 16'd41943;
    localparam logic [DIVIN_W-1:0] DIV25 = 13'd25;

    typedef logic [SERIAL_W-1:0] serial_t;

    // Days before the first of month index 0..11
    function automatic logic [DBM_W-1:0] days_before_month(input logic leap,
                                                           input logic [3:0] idx);
        logic [DBM_W-1:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            default: base = 9'd334;
        endcase
        if (leap && (idx >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== hdl/ddd_serial.sv =====
// Three-stage day serial pipeline for one date: days before year + month + day.
// Depends on ddd_pkg.
module ddd_serial (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ddd_pkg::YEAR_W-1:0]  year,
    input  logic [ddd_pkg::MONTH_W-1:0] month,
    input  logic [ddd_pkg::DAY_W-1:0]   day,
    output ddd_pkg::serial_t            serial
);
    import ddd_pkg::*;

    // quotient estimate of v / 25, low by at most one
    function automatic logic [QUO_W-1:0] quo25_est(input logic [DIVIN_W-1:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'(RECIP25);
        return p[28:20];
    endfunction

    // divider slots: 0 = (y+99)/4, 1 = (y+399)/16, 2 = y/4, 3 = y/16
    localparam int NDIV = 4;

    logic [YEAR_W:0]    y99;
    logic [YEAR_W:0]    y399;
    logic [DIVIN_W-1:0] div_in [NDIV];
    logic [3:0]         m_idx;

    // stage 1 registers
    logic [YEAR_W-1:0]  s1_year_reg;
    logic [3:0]         s1_idx_reg;
    logic [DAY_W-1:0]   s1_day_reg;
    logic [DIVIN_W-1:0] s1_v_reg [NDIV];
    logic [QUO_W-1:0]   s1_q_reg [NDIV];

    // stage 2 signals and registers
    logic [QUO_W-1:0]   q_fix [NDIV];
    logic [DIVIN_W-1:0] r_fix [NDIV];
    logic               leap;
    logic [YEAR_W-1:0]  s2_year_reg;
    logic [QUO_W-1:0]   s2_c100_reg;
    logic [QUO_W-1:0]   s2_c400_reg;
    logic [DBM_W-1:0]   s2_dbm_reg;
    logic [DAY_W-1:0]   s2_day_reg;

    // stage 3
    serial_t            serial_next;
    serial_t            serial_reg;

    // month clamp and divider operands
    always_comb
    begin
        y99  = {1'b0, year} + 15'd99;
        y399 = {1'b0, year} + 15'd399;
        div_in[0] = y99[14:2];
        div_in[1] = {2'b00, y399[14:4]};
        div_in[2] = {1'b0, year[13:2]};
        div_in[3] = {3'b000, year[13:4]};
        if (month == 4'd0)
        begin
            m_idx = 4'd0;
        end
        else if (month inside {[4'd13:4'd15]})
        begin
            m_idx = 4'd11;
        end
        else
        begin
            m_idx = month - 4'd1;
        end
    end

    // stage 1: reciprocal multiplies
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_year_reg <= year;
            s1_idx_reg  <= m_idx;
            s1_day_reg  <= day;
            for (int k = 0; k < NDIV; k++)
            begin
                s1_v_reg[k] <= div_in[k];
                s1_q_reg[k] <= quo25_est(div_in[k]);
            end
        end
    end

    // stage 2: quotient correction, leap flag, month table
    always_comb
    begin
        for (int k = 0; k < NDIV; k++)
        begin
            r_fix[k] = s1_v_reg[k] - DIVIN_W'(s1_q_reg[k]) * DIV25;
            q_fix[k] = s1_q_reg[k];
            if (r_fix[k] >= DIV25)
            begin
                r_fix[k] = r_fix[k] - DIV25;
                q_fix[k] = q_fix[k] + 9'd1;
            end
        end
        // divisible by 4 and not by 100, or divisible by 400
        leap = (s1_year_reg[1:0] == 2'b00) &&
               ((r_fix[2] != '0) || ((s1_year_reg[3:0] == 4'h0) && (r_fix[3] == '0)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_year_reg <= s1_year_reg;
            s2_c100_reg <= q_fix[0];
            s2_c400_reg <= q_fix[1];
            s2_dbm_reg  <= days_before_month(leap, s1_idx_reg);
            s2_day_reg  <= s1_day_reg;
        end
    end

    // stage 3: closed-form serial
    always_comb
    begin
        serial_next = SERIAL_W'(s2_year_reg) * 23'd365
                    + SERIAL_W'((({1'b0, s2_year_reg} + 15'd3) >> 2))
                    - SERIAL_W'(s2_c100_reg)
                    + SERIAL_W'(s2_c400_reg)
                    + SERIAL_W'(s2_dbm_reg)
                    + SERIAL_W'(s2_day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            serial_reg <= serial_next;
        end
    end

    assign serial = serial_reg;

endmodule

// ===== hdl/date_day_difference.sv =====
// Top level of the Gregorian date difference block: stream ports, valid
// pipeline and the final subtract/saturate stage. Depends on ddd_pkg,
// ddd_serial and assert_macros.svh.
//
// Usage:
//   One input transfer on s_axis carries two dates; one output transfer on
//   m_axis carries the absolute number of days between them, saturated to
//   22 bits. Every input transfer yields exactly one output transfer, in order.
//   m_axis_tvalid rises over four register stages: three build each date's
//   day serial (reciprocal divide by 25, quotient correction and month table,
//   closed-form sum), the first loaded at the accepting edge, and one subtracts.
//   Throughput is one transfer per cycle while m_axis_tready is high; the
//   whole pipeline advances on a single enable.
//   When the receiver stalls with a result waiting, the whole pipeline freezes
//   and s_axis_tready drops until that result is taken.
//   Reset (rst_n low, asynchronous) empties the pipeline; no output is valid
//   and s_axis_tready is high right after reset.
`include "assert_macros.svh"

module date_day_difference (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [13:0] first_year, [17:14] first_month, [22:18] first_day,
    // [36:23] second_year, [40:37] second_month, [45:41] second_day, [47:46] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [21:0] day_count, [23:22] zero
    output logic [23:0] m_axis_tdata
);
    import ddd_pkg::*;

    logic                ce;
    logic [2:0]          vld_reg;
    logic [2:0]          vld_next;
    logic                out_vld_reg;
    serial_t             serial_a;
    serial_t             serial_b;
    serial_t             diff;
    logic [COUNT_W-1:0]  count_next;
    logic [COUNT_W-1:0]  count_reg;

    // pipeline advances unless a finished result is held
    assign ce            = m_axis_tready || !out_vld_reg;
    assign s_axis_tready = ce;

    // per-date serial pipelines
    ddd_serial u_serial_a (
        .clk    (clk),
        .en     (ce),
        .year   (s_axis_tdata[13:0]),
        .month  (s_axis_tdata[17:14]),
        .day    (s_axis_tdata[22:18]),
        .serial (serial_a)
    );

    ddd_serial u_serial_b (
        .clk    (clk),
        .en     (ce),
        .year   (s_axis_tdata[36:23]),
        .month  (s_axis_tdata[40:37]),
        .day    (s_axis_tdata[45:41]),
        .serial (serial_b)
    );

    // valid bits travel with the serial stages
    assign vld_next = {vld_reg[1:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[2];
        end
    end

    // absolute difference with saturation
    always_comb
    begin
        diff = (serial_a > serial_b) ? (serial_a - serial_b) : (serial_b - serial_a);
        if (diff > SERIAL_W'(COUNT_MAX))
        begin
            count_next = COUNT_MAX;
        end
        else
        begin
            count_next = diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            count_reg <= count_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, count_reg};

    // a held result must block input
    `DDD_ASSERT_IMP(a_stall_blocks_in, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input accepted while output stalled")
    // an accepted transfer enters the first stage
    `DDD_ASSERT_NXT(a_accept_fills_s1, clk, rst_n, s_axis_tvalid && s_axis_tready, vld_reg[0], "accepted transfer lost at stage 1")
    // a frozen pipeline keeps its valid bits
    `DDD_ASSERT_NXT(a_stall_holds_pipe, clk, rst_n, !s_axis_tready, $stable(vld_reg) && m_axis_tvalid, "pipeline moved during stall")

endmodule
